### hdl/pqs_pkg.sv
// Package for the periodic query scheduler: status codes and the
// command and status bundles between the controller and the datapath.
// No dependencies.
package pqs_pkg;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_FULL        = 2'd1,
    ST_EMPTY       = 2'd2,
    ST_ZERO_PERIOD = 2'd3
  } pqs_status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        load;       // capture the request fields
    logic        write_new;  // store a new entry at the fill position
    logic        scan_clear; // restart the scan at entry zero, forget the best
    logic        rd_issue;   // read the addressed entry and step the address unless it is the last
    logic        update;     // write back the advanced due time of the best
    logic        emit;       // present one result beat
    pqs_status_t status;     // status code of the emitted beat
  } pqs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_fire;
    logic per_zero;
    logic full;
    logic empty;
    logic scan_last;
  } pqs_stat_t;

endpackage

### hdl/pqs_dp.sv
// Datapath of the periodic query scheduler: entry memory, fill count,
// scan address, running minimum and result registers. Uses pqs_pkg.
module pqs_dp #(
  parameter int MAX_QUERIES = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  pqs_pkg::pqs_cmd_t  cmd,
  output pqs_pkg::pqs_stat_t stat,
  input  logic             in_req_type,
  input  logic [15:0]      in_query_id,
  input  logic [15:0]      in_period,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [15:0]      out_fired_id,
  output logic [31:0]      out_fire_time
);
  import pqs_pkg::*;

  localparam int IDX_W = (MAX_QUERIES > 1) ? $clog2(MAX_QUERIES) : 1;
  localparam int CNT_W = $clog2(MAX_QUERIES + 1);
  localparam int ENT_W = 64;

  // Entry layout: {query id, period, due time}.
  logic [ENT_W-1:0] mem [MAX_QUERIES];

  logic             req_type_r;
  logic [15:0]      query_id_r;
  logic [15:0]      period_r;
  logic [CNT_W-1:0] count_r;
  logic [IDX_W-1:0] rd_addr_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic [ENT_W-1:0] rd_data_r;
  logic             cmp_v_r;
  logic             best_set_r;
  logic [IDX_W-1:0] best_idx_r;
  logic [15:0]      best_id_r;
  logic [15:0]      best_per_r;
  logic [31:0]      best_due_r;
  logic             out_valid_r;
  logic [1:0]       out_status_r;
  logic [15:0]      out_fired_id_r;
  logic [31:0]      out_fire_time_r;

  logic [15:0]      rd_id;
  logic [15:0]      rd_per;
  logic [31:0]      rd_due;
  logic             take;
  logic [32:0]      due_sum;
  logic [31:0]      due_next;

  assign rd_id  = rd_data_r[63:48];
  assign rd_per = rd_data_r[47:32];
  assign rd_due = rd_data_r[31:0];

  // Strictly earlier due time wins; equal due time goes to the smaller id,
  // and a full tie keeps the lower slot already held.
  assign take = !best_set_r || (rd_due < best_due_r) ||
                ((rd_due == best_due_r) && (rd_id < best_id_r));

  assign due_sum  = {1'b0, best_due_r} + {17'b0, best_per_r};
  assign due_next = due_sum[32] ? 32'hFFFF_FFFF : due_sum[31:0];

  assign stat.is_fire   = req_type_r;
  assign stat.per_zero  = (period_r == 16'd0);
  assign stat.full      = (count_r == CNT_W'(MAX_QUERIES));
  assign stat.empty     = (count_r == '0);
  assign stat.scan_last = (CNT_W'(rd_addr_r) == count_r - 1'b1);

  always_ff @(posedge clk) begin
    if (cmd.write_new) begin
      mem[count_r[IDX_W-1:0]] <= {query_id_r, period_r, 16'd0, period_r};
    end else if (cmd.update) begin
      mem[best_idx_r] <= {best_id_r, best_per_r, due_next};
    end
    rd_data_r <= mem[rd_addr_r];
    rd_idx_r  <= rd_addr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cmp_v_r     <= 1'b0;
      best_set_r  <= 1'b0;
      out_valid_r <= 1'b0;
      rd_addr_r   <= '0;
    end else begin
      cmp_v_r     <= cmd.rd_issue;
      out_valid_r <= cmd.emit;
      if (cmd.write_new) begin
        count_r <= count_r + 1'b1;
      end
      if (cmd.scan_clear) begin
        rd_addr_r  <= '0;
        best_set_r <= 1'b0;
      end else begin
        if (cmd.rd_issue && !stat.scan_last) begin
          rd_addr_r <= rd_addr_r + 1'b1;
        end
        if (cmp_v_r && take) begin
          best_set_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type_r <= in_req_type;
      query_id_r <= in_query_id;
      period_r   <= in_period;
    end
    if (cmp_v_r && take) begin
      best_idx_r <= rd_idx_r;
      best_id_r  <= rd_id;
      best_per_r <= rd_per;
      best_due_r <= rd_due;
    end
    if (cmd.emit) begin
      out_status_r    <= cmd.status;
      out_fired_id_r  <= cmd.update ? best_id_r : 16'd0;
      out_fire_time_r <= cmd.update ? best_due_r : 32'd0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_fired_id  = out_fired_id_r;
  assign out_fire_time = out_fire_time_r;

endmodule

### hdl/pqs_ctrl.sv
// Controller of the periodic query scheduler: sequences registration
// and the fire scan over the entry memory. Uses pqs_pkg.
module pqs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  pqs_pkg::pqs_stat_t stat,
  output pqs_pkg::pqs_cmd_t  cmd
);
  import pqs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_DRAIN,
    S_UPDATE
  } state_t;

  state_t state_r;
  logic   busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_DISPATCH;
            busy_r  <= 1'b1;
          end
        end
        S_DISPATCH: begin
          if (stat.is_fire && !stat.empty) begin
            state_r <= S_SCAN;
          end else begin
            state_r <= S_IDLE;
            busy_r  <= 1'b0;
          end
        end
        S_SCAN: begin
          if (stat.scan_last) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_r <= S_UPDATE;
        end
        S_UPDATE: begin
          state_r <= S_IDLE;
          busy_r  <= 1'b0;
        end
        default: begin
          state_r <= S_IDLE;
          busy_r  <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    cmd.status = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = start;
      end
      S_DISPATCH: begin
        if (stat.is_fire) begin
          if (stat.empty) begin
            cmd.emit   = 1'b1;
            cmd.status = ST_EMPTY;
          end else begin
            cmd.scan_clear = 1'b1;
          end
        end else begin
          cmd.emit = 1'b1;
          priority if (stat.per_zero) begin
            cmd.status = ST_ZERO_PERIOD;
          end else if (stat.full) begin
            cmd.status = ST_FULL;
          end else begin
            cmd.write_new = 1'b1;
            cmd.status    = ST_OK;
          end
        end
      end
      S_SCAN: begin
        cmd.rd_issue = 1'b1;
      end
      S_DRAIN: begin
        cmd.status = ST_OK;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        cmd.emit   = 1'b1;
        cmd.status = ST_OK;
      end
      default: begin
        cmd.status = ST_OK;
      end
    endcase
  end

  assign busy = busy_r;

endmodule

### hdl/periodic_query_scheduler.sv
// Periodic query scheduler, top level: joins the controller and the
// datapath. Depends on pqs_pkg, pqs_ctrl and pqs_dp.
//
// Usage: a request beat is taken on a rising edge where start is high and
// busy is low. in_req_type selects the request: zero registers a query
// with in_query_id and in_period, one fires the query due earliest (ties
// go to the smaller id, then to the older entry). Every request yields
// exactly one result beat, marked by out_valid for one cycle, carrying
// out_status, out_fired_id and out_fire_time. The receiver cannot stall
// the block, so it must take each beat in the cycle it appears.
//
// Sequencing: a register request is decided in the dispatch state. A fire
// request scans the stored entries one per cycle through the single read
// port of the entry memory, finishes the last compare in a drain state
// and presents its result from the update state (from the dispatch state
// on an empty table). busy stays high until the result beat is
// presented, and a new request may be taken in the same cycle that the
// result is shown. The scan loop sets the rate: one request at a time.
//
// Reset (rst_n low, synchronous) empties the table by clearing the fill
// count; entries fill in order and never leave, so no memory sweep is
// needed and the block is ready right after reset.
module periodic_query_scheduler #(
  parameter int MAX_QUERIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic [15:0] in_query_id,
  input  logic [15:0] in_period,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [15:0] out_fired_id,
  output logic [31:0] out_fire_time
);
  import pqs_pkg::*;

  pqs_cmd_t  cmd;
  pqs_stat_t stat;

  // The controller only sees status flags and drives the command bundle.
  pqs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // The datapath holds the table, the scan and the result registers.
  pqs_dp #(
    .MAX_QUERIES (MAX_QUERIES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_req_type   (in_req_type),
    .in_query_id   (in_query_id),
    .in_period     (in_period),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_fired_id  (out_fired_id),
    .out_fire_time (out_fire_time)
  );

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the periodic query scheduler: a request driver, a result
// monitor and a mirror of the query table that predicts every result beat.
// Depends on pqs_pkg and periodic_query_scheduler.
module tb_top;
  import pqs_pkg::*;

  localparam int TABLE_SLOTS = 64;
  // A short run of fires on a single entry of the largest period; each fire
  // steps its due time by the whole period.
  localparam int SINGLE_FIRES = 4;
  localparam int RANDOM_ITEMS = 1400;
  // Long enough for a fire on a full table, so this covers any late beat.
  localparam int SETTLE_CYCLES = 80;
  // Longest honest silence: the longest idle gap that pick_gap draws
  // followed by a full-table scan. The limit is several times that.
  localparam int STALL_LIMIT = 1000;
  localparam int PRINT_LIMIT = 40;

  localparam logic REQ_REGISTER = 1'b0;
  localparam logic REQ_FIRE = 1'b1;

  typedef struct {
    logic        req_type;
    logic [15:0] query_id;
    logic [15:0] period;
    int          gap;       // idle cycles before this beat is offered
  } request_t;

  typedef struct {
    pqs_status_t status;
    logic [15:0] fired_id;
    logic [31:0] fire_time;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_req_type = 1'b0;
  logic [15:0] in_query_id = '0;
  logic [15:0] in_period = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [15:0] out_fired_id;
  logic [31:0] out_fire_time;

  request_t request_queue[$];
  outcome_t awaited_results[$];
  request_t next_req;
  outcome_t want;
  int       err_count = 0;
  int       stall_cycles = 0;

  // Mirror of the query table. Entries never leave, so the table only grows.
  logic        mirror_valid[TABLE_SLOTS];
  logic [15:0] mirror_id[TABLE_SLOTS];
  logic [15:0] mirror_period[TABLE_SLOTS];
  logic [31:0] mirror_due[TABLE_SLOTS];

  periodic_query_scheduler #(
    .MAX_QUERIES(TABLE_SLOTS)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_req_type  (in_req_type),
    .in_query_id  (in_query_id),
    .in_period    (in_period),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_fired_id (out_fired_id),
    .out_fire_time(out_fire_time)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      mirror_valid[i] = 1'b0;
    end
  end

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= PRINT_LIMIT) begin
      $display("mismatch at %0t ns: %s", $time, what);
    end
  endtask

  // Applies one accepted request to the mirror table and queues the result
  // beat that the block must produce for it.
  task automatic apply_request(input logic req_type, input logic [15:0] qid,
                               input logic [15:0] per);
    outcome_t    res;
    int          best;
    int          slot;
    logic [32:0] next_due;
    res.status = ST_OK;
    res.fired_id = '0;
    res.fire_time = '0;
    if (req_type == REQ_REGISTER) begin
      // A zero period is rejected before the table is looked at, so it wins
      // over a full table.
      if (per == 16'd0) begin
        res.status = ST_ZERO_PERIOD;
      end else begin
        slot = -1;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (slot < 0 && !mirror_valid[i]) slot = i;
        end
        if (slot < 0) begin
          res.status = ST_FULL;
        end else begin
          mirror_valid[slot] = 1'b1;
          mirror_id[slot] = qid;
          mirror_period[slot] = per;
          mirror_due[slot] = {16'd0, per};
        end
      end
    end else begin
      // Earliest due time wins; on a tie the smaller id, and on equal ids
      // the lower slot, since a later slot must be strictly better.
      best = -1;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        if (mirror_valid[i]) begin
          if (best < 0 || mirror_due[i] < mirror_due[best] ||
              (mirror_due[i] == mirror_due[best] && mirror_id[i] < mirror_id[best])) begin
            best = i;
          end
        end
      end
      if (best < 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.fired_id = mirror_id[best];
        res.fire_time = mirror_due[best];
        next_due = {1'b0, mirror_due[best]} + {17'd0, mirror_period[best]};
        mirror_due[best] = next_due[32] ? 32'hFFFF_FFFF : next_due[31:0];
      end
    end
    awaited_results.push_back(res);
  endtask

  // Stimulus helpers: ids lean toward a few small values so that ties are
  // common, periods mix small, full-range, zero and near-maximum values.
  function automatic logic [15:0] pick_id();
    if ($urandom_range(0, 1) == 0) return 16'($urandom_range(0, 7));
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 16'($urandom_range(1, 16));
    if (r < 75) return 16'($urandom);
    if (r < 85) return 16'd0;
    return 16'($urandom_range(16'hFF00, 16'hFFFF));
  endfunction

  // About three requests in ten are preceded by idle cycles. Most gaps are
  // short, but some are long enough to end anywhere inside a full-table scan.
  function automatic int pick_gap(input bit quiet);
    if (quiet) return 0;
    if ($urandom_range(0, 99) >= 31) return 0;
    if ($urandom_range(0, 7) == 0) return $urandom_range(4, 80);
    return $urandom_range(1, 3);
  endfunction

  task automatic add_request(input logic req_type, input logic [15:0] qid,
                             input logic [15:0] per, input int gap);
    request_t req;
    req.req_type = req_type;
    req.query_id = qid;
    req.period = per;
    req.gap = gap;
    request_queue.push_back(req);
  endtask

  // Driver. A beat is taken on an edge where start is high and busy is low.
  // Once offered, a beat is held until taken; a new one may be offered in
  // the very cycle the previous one is taken. While idle, the request
  // fields carry noise that the block must ignore.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_req_type <= 1'b0;
      in_query_id <= '0;
      in_period <= '0;
    end else begin
      if (start && !busy) begin
        apply_request(in_req_type, in_query_id, in_period);
      end
      if (start && busy) begin
        // The offered beat stays on the ports until the block takes it.
      end else if (request_queue.size() != 0 && request_queue[0].gap == 0) begin
        next_req = request_queue.pop_front();
        start <= 1'b1;
        in_req_type <= next_req.req_type;
        in_query_id <= next_req.query_id;
        in_period <= next_req.period;
      end else begin
        if (request_queue.size() != 0) begin
          request_queue[0].gap = request_queue[0].gap - 1;
        end
        start <= 1'b0;
        in_req_type <= 1'($urandom);
        in_query_id <= 16'($urandom);
        in_period <= 16'($urandom);
      end
    end
  end

  // Monitor. Every result beat must match the oldest prediction field by
  // field; the block cannot be stalled, so each strobe is one beat.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result beat with no request outstanding");
      end else begin
        want = awaited_results.pop_front();
        if (out_status !== want.status) begin
          report_mismatch($sformatf("status %0d, predicted %s", out_status,
                                    want.status.name()));
        end
        if (out_fired_id !== want.fired_id) begin
          report_mismatch($sformatf("fired id %h, predicted %h", out_fired_id,
                                    want.fired_id));
        end
        if (out_fire_time !== want.fire_time) begin
          report_mismatch($sformatf("fire time %h, predicted %h", out_fire_time,
                                    want.fire_time));
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither a request nor a result beat
  // moves, and ends the run if the block goes silent for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    bit quiet;
    int r;

    // Directed part. A fire on the empty table comes first, then a zero
    // period while the table is still empty.
    add_request(REQ_FIRE, 16'hFFFF, 16'hFFFF, 0);
    add_request(REQ_REGISTER, 16'hFFFF, 16'h0000, 0);
    add_request(REQ_REGISTER, 16'hFFFF, 16'hFFFF, 1);

    // With a single entry of the largest period, fire a few times back to
    // back with no idle cycles; the due time climbs by the full period.
    for (int k = 0; k < SINGLE_FIRES; k++) begin
      add_request(REQ_FIRE, 16'($urandom), 16'($urandom), 0);
    end

    // Equal due times: the smaller id wins even from a higher slot.
    add_request(REQ_REGISTER, 16'd5, 16'd10, 2);
    add_request(REQ_REGISTER, 16'd3, 16'd10, 0);
    add_request(REQ_FIRE, 16'h0000, 16'h0000, 0);
    add_request(REQ_FIRE, 16'hFFFF, 16'hFFFF, 1);
    // Duplicate ids with the same period tie on both keys; the lower slot
    // wins. Four entries are due at the same time here.
    add_request(REQ_REGISTER, 16'd7, 16'd20, 0);
    add_request(REQ_REGISTER, 16'd7, 16'd20, 3);
    add_request(REQ_FIRE, 16'h0000, 16'h0000, 0);
    add_request(REQ_FIRE, 16'h0000, 16'h0000, 0);
    add_request(REQ_FIRE, 16'h0000, 16'h0000, 2);
    add_request(REQ_FIRE, 16'h0000, 16'h0000, 0);
    // Smallest id and smallest period, then a mid-range pair.
    add_request(REQ_REGISTER, 16'h0000, 16'h0001, 0);
    add_request(REQ_FIRE, 16'h0000, 16'h0000, 0);
    add_request(REQ_REGISTER, 16'h8000, 16'h8000, 1);
    add_request(REQ_FIRE, 16'h0000, 16'h0000, 0);
    add_request(REQ_FIRE, 16'h0000, 16'h0000, 0);

    // Random part. Registers dominate at first so the table fills and then
    // overflows; after that, fires on a full table, rejected registers and
    // zero periods mix. One stretch runs with no idle cycles.
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      quiet = (k >= 600 && k < 800);
      r = $urandom_range(0, 99);
      if (r < ((k < 150) ? 60 : 30)) begin
        add_request(REQ_REGISTER, pick_id(), pick_period(), pick_gap(quiet));
      end else begin
        add_request(REQ_FIRE, 16'($urandom), 16'($urandom), pick_gap(quiet));
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Wait on the falling edge so that every update of the rising edge has
    // settled before the queues are looked at.
    do begin
      @(negedge clk);
    end while (request_queue.size() != 0 || start || awaited_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (awaited_results.size() != 0) begin
      report_mismatch($sformatf("%0d predicted results never arrived",
                                awaited_results.size()));
    end
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
hdl/pqs_pkg.sv
hdl/pqs_dp.sv
hdl/pqs_ctrl.sv
hdl/periodic_query_scheduler.sv
sim/tb_top.sv
